FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent checks used on the display formatter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// What must hold in the cycle after a reset edge.
`define ASSERT_RST(lbl, clk, rstn, cons, msg) \
    lbl: assert property (@(posedge clk) (!rstn) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg
// Types, codes and constants shared by the display formatter modules.
// ----------------------------------------------------------------------------
package ssf_pkg;

    // Command codes on the input channel
    localparam logic [1:0] CMD_LOAD_INT = 2'd0;
    localparam logic [1:0] CMD_LOAD_FIX = 2'd1;
    localparam logic [1:0] CMD_SCAN     = 2'd2;

    // Point positions; zero means no point
    localparam logic [1:0] POINT_NONE = 2'd0;
    localparam logic [1:0] POINT_TWO  = 2'd2;
    localparam logic [1:0] POINT_THREE = 2'd3;

    // Digit position of the minus glyph
    localparam logic [1:0] MINUS_POS = 2'd3;

    localparam logic [7:0] SEG_POINT = 8'h80;
    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    // Operand width of the digit split (magnitudes below 2^17)
    localparam int X_W = 17;
    localparam int PROD_W = 35;

    // Reciprocals: ceil(2^s / d), exact for all 17-bit operands
    localparam logic [17:0] RECIP_10    = 18'd209716;
    localparam logic [17:0] RECIP_100   = 18'd167773;
    localparam logic [17:0] RECIP_1000  = 18'd134218;
    localparam logic [17:0] RECIP_10000 = 18'd214749;
    localparam int SHIFT_10    = 21;
    localparam int SHIFT_100   = 24;
    localparam int SHIFT_1000  = 27;
    localparam int SHIFT_10000 = 31;

    // Value ranges of the loads
    localparam logic signed [17:0] INT_MAX     = 18'sd9999;
    localparam logic signed [17:0] FIX_HI_MIN  = 18'sd10000;
    localparam logic signed [17:0] FIX_HI_MAX  = 18'sd99999;
    localparam logic signed [17:0] FIX_LO_MIN  = -18'sd999;
    localparam logic signed [17:0] FIX_LO_MAX  = 18'sd9999;
    localparam logic signed [17:0] FIX_NEG_MIN = -18'sd9999;
    localparam logic signed [17:0] FIX_NEG_MAX = -18'sd1000;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Classification made by the front end
    typedef enum logic [2:0] {
        KIND_INT,
        KIND_FIX_HI,
        KIND_FIX_LO,
        KIND_FIX_NEG,
        KIND_ZERO,
        KIND_SCAN
    } kind_t;

    typedef logic [3:0] digit_t;

    // One operation for the back end
    typedef struct packed {
        logic             is_scan;
        digit_t [3:0]     digits;
        logic             minus;
        logic [1:0]       point;
        logic [1:0]       index;
    } op_t;

    // Seven-segment pattern of a decimal digit; blank above nine
    function automatic logic [7:0] glyph(input digit_t d);
        logic [7:0] g;
        unique case (d)
            4'd0:    g = 8'h3F;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5B;
            4'd3:    g = 8'h4F;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6D;
            4'd6:    g = 8'h7D;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7F;
            4'd9:    g = 8'h6F;
            default: g = SEG_BLANK;
        endcase
        return g;
    endfunction

    // hi - 10*lo, modulo 16; exact when the true digit lies in 0..9
    function automatic digit_t sub_ten(input digit_t hi, input digit_t lo);
        digit_t ten_lo;
        ten_lo = (lo << 3) + (lo << 1);
        return hi - ten_lo;
    endfunction

endpackage

FILE: hdl/ssf_front.sv
// ----------------------------------------------------------------------------
// ssf_front
// Accepts items, classifies loads and splits their value into digits.
// ----------------------------------------------------------------------------
module ssf_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_command,
    input  logic signed [17:0]      s_value,
    input  logic [1:0]              s_digit_index,
    output logic                    op_valid,
    input  logic                    op_ready,
    output ssf_pkg::op_t            op_data
);
    import ssf_pkg::*;

    // stage A: classified operand
    logic                a_valid_reg, a_valid_next;
    kind_t               a_kind_reg, a_kind_next;
    logic [X_W-1:0]      a_x_reg, a_x_next;
    logic [1:0]          a_index_reg;

    // stage B: low digits of the quotients
    logic                b_valid_reg, b_valid_next;
    kind_t               b_kind_reg;
    logic [1:0]          b_index_reg;
    digit_t              b_x_reg, b_q10_reg, b_q100_reg, b_q1000_reg, b_q10000_reg;

    logic                a_ready, b_ready, accept;
    logic                neg;
    logic [17:0]         mag;
    logic [PROD_W-1:0]   p10, p100, p1000, p10000;
    digit_t              e3, e2, e1, e0, f0;

    assign b_ready = !b_valid_reg || op_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;
    assign accept  = s_valid && a_ready;

    // classification
    assign neg = s_value[17];
    assign mag = neg ? 18'(-s_value) : s_value;

    always_comb begin
        a_kind_next = KIND_ZERO;
        a_x_next    = mag[X_W-1:0];
        unique case (s_command)
            CMD_LOAD_INT: begin
                a_kind_next = KIND_INT;
                priority if (neg)               a_x_next = '0;
                else if (s_value > INT_MAX)     a_x_next = X_W'(INT_MAX);
                else                            a_x_next = s_value[X_W-1:0];
            end
            CMD_LOAD_FIX: begin
                priority if (s_value >= FIX_HI_MIN && s_value <= FIX_HI_MAX)
                    a_kind_next = KIND_FIX_HI;
                else if (s_value >= FIX_LO_MIN && s_value <= FIX_LO_MAX)
                    a_kind_next = KIND_FIX_LO;
                else if (s_value >= FIX_NEG_MIN && s_value <= FIX_NEG_MAX)
                    a_kind_next = KIND_FIX_NEG;
                else
                    a_kind_next = KIND_ZERO;
            end
            default: a_kind_next = KIND_SCAN;
        endcase
    end

    // unused command code is taken and dropped here
    always_comb begin
        a_valid_next = a_valid_reg;
        if (a_ready) begin
            a_valid_next = s_valid && (s_command == CMD_LOAD_INT
                || s_command == CMD_LOAD_FIX || s_command == CMD_SCAN);
        end
    end

    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    // reciprocal multiplies, in parallel
    assign p10    = PROD_W'(a_x_reg) * PROD_W'(RECIP_10);
    assign p100   = PROD_W'(a_x_reg) * PROD_W'(RECIP_100);
    assign p1000  = PROD_W'(a_x_reg) * PROD_W'(RECIP_1000);
    assign p10000 = PROD_W'(a_x_reg) * PROD_W'(RECIP_10000);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_kind_reg  <= a_kind_next;
            a_x_reg     <= a_x_next;
            a_index_reg <= s_digit_index;
        end
        if (b_ready && a_valid_reg) begin
            b_kind_reg   <= a_kind_reg;
            b_index_reg  <= a_index_reg;
            b_x_reg      <= a_x_reg[3:0];
            b_q10_reg    <= p10[SHIFT_10 +: 4];
            b_q100_reg   <= p100[SHIFT_100 +: 4];
            b_q1000_reg  <= p1000[SHIFT_1000 +: 4];
            b_q10000_reg <= p10000[SHIFT_10000 +: 4];
        end
    end

    // digits from neighbouring quotients
    assign e3 = b_q10000_reg;
    assign e2 = sub_ten(b_q1000_reg, b_q10000_reg);
    assign e1 = sub_ten(b_q100_reg, b_q1000_reg);
    assign e0 = sub_ten(b_q10_reg, b_q100_reg);
    assign f0 = sub_ten(b_x_reg, b_q10_reg);

    always_comb begin
        op_data         = '0;
        op_data.index   = b_index_reg;
        unique case (b_kind_reg)
            KIND_INT: begin
                op_data.digits = {e2, e1, e0, f0};
            end
            KIND_FIX_HI: begin
                op_data.digits = {e3, e2, e1, e0};
                op_data.point  = POINT_TWO;
            end
            KIND_FIX_LO: begin
                op_data.digits = {e2, e1, e0, f0};
                op_data.point  = POINT_THREE;
            end
            KIND_FIX_NEG: begin
                op_data.digits = {4'd0, e2, e1, e0};
                op_data.minus  = 1'b1;
                op_data.point  = POINT_TWO;
            end
            KIND_SCAN: begin
                op_data.is_scan = 1'b1;
            end
            default: begin
                op_data.point = POINT_NONE;
            end
        endcase
    end

    assign op_valid = b_valid_reg;

endmodule

FILE: hdl/ssf_queue.sv
// ----------------------------------------------------------------------------
// ssf_queue
// Small first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
module ssf_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  ssf_pkg::op_t    wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output ssf_pkg::op_t    rd_data
);
    import ssf_pkg::*;

    op_t                    entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]      count_reg, count_next;
    logic                   push, pop;

    assign wr_ready = count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hdl/ssf_back.sv
// ----------------------------------------------------------------------------
// ssf_back
// Applies loads to the display state and turns scans into segment patterns.
// ----------------------------------------------------------------------------
module ssf_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            op_valid,
    output logic            op_ready,
    input  ssf_pkg::op_t    op_data,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_segments,
    output logic [3:0]      m_digit_enable
);
    import ssf_pkg::*;

    digit_t [3:0]   digit_reg, digit_next;
    logic           minus_reg, minus_next;
    logic [1:0]     point_reg, point_next;
    logic           m_valid_reg, m_valid_next;
    logic [7:0]     m_segments_reg, seg_next;
    logic [3:0]     m_digit_enable_reg, enable_next;
    logic           out_free, take, load, scan;

    assign out_free = !m_valid_reg || m_ready;
    assign op_ready = !op_data.is_scan || out_free;
    assign take     = op_valid && op_ready;
    assign load     = take && !op_data.is_scan;
    assign scan     = take && op_data.is_scan;

    always_comb begin
        digit_next = digit_reg;
        minus_next = minus_reg;
        point_next = point_reg;
        if (load) begin
            digit_next = op_data.digits;
            minus_next = op_data.minus;
            point_next = op_data.point;
        end
    end

    always_comb begin
        if (op_data.index == MINUS_POS && minus_reg) begin
            seg_next = SEG_MINUS;
        end else begin
            seg_next = glyph(digit_reg[op_data.index]);
        end
        if (point_reg != POINT_NONE && op_data.index == point_reg) begin
            seg_next = seg_next | SEG_POINT;
        end
        enable_next = 4'b0001 << op_data.index;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (scan)          m_valid_next = 1'b1;
        else if (m_ready)  m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg   <= '0;
            minus_reg   <= 1'b0;
            point_reg   <= POINT_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            digit_reg   <= digit_next;
            minus_reg   <= minus_next;
            point_reg   <= point_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (scan) begin
            m_segments_reg     <= seg_next;
            m_digit_enable_reg <= enable_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_segments     = m_segments_reg;
    assign m_digit_enable = m_digit_enable_reg;

endmodule

FILE: hdl/seven_segment_four_digit_formatter.sv
// ----------------------------------------------------------------------------
// seven_segment_four_digit_formatter
// Formats numbers for a four-digit multiplexed seven-segment display.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Ports                                    Transfer carries
//  s_       in   s_command s_value s_digit_index          load int/fixed, scan
//  m_       out  m_segments m_digit_enable                pattern of one digit
//
//  One transfer per cycle is taken on s_ while m_ is not stalled; loads and scans
//  mix freely. A scan's result reaches m_ through stage A (loaded by the transfer
//  itself), stage B, one queue slot and the output register, in that order.
//  The front's digit split uses four reciprocal multiplies side by side and
//  sets the stage timing.
//  Reset (aresetn low at a clock edge) empties every stage at once and shows
//  a display of zeros with no minus and no point; no clearing pass.
//  A stall on m_ holds a scan at the head of the four-entry queue; loads ahead
//  of it still drain. s_ready falls only once queue and front stages are full.
//
// ----------------------------------------------------------------------------
module seven_segment_four_digit_formatter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_command,
    input  logic signed [17:0]  s_value,
    input  logic [1:0]          s_digit_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_segments,
    output logic [3:0]          m_digit_enable
);
    import ssf_pkg::*;

    // front -> queue
    logic   f_valid, f_ready;
    op_t    f_data;
    // queue -> back
    logic   q_valid, q_ready;
    op_t    q_data;

    // Front: takes every transfer, drops the unused command, classifies
    // loads by range and splits the value into four decimal digits.
    ssf_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_value        (s_value),
        .s_digit_index  (s_digit_index),
        .op_valid       (f_valid),
        .op_ready       (f_ready),
        .op_data        (f_data)
    );

    // Queue: lets the front run on while the result side is stalled.
    ssf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_valid   (f_valid),
        .wr_ready   (f_ready),
        .wr_data    (f_data),
        .rd_valid   (q_valid),
        .rd_ready   (q_ready),
        .rd_data    (q_data)
    );

    // Back: owns the digit store, minus flag and point position. Loads are
    // applied in order, so a scan always sees every earlier load.
    ssf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .op_valid       (q_valid),
        .op_ready       (q_ready),
        .op_data        (q_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_segments     (m_segments),
        .m_digit_enable (m_digit_enable)
    );

endmodule

FILE: hdl/ssf_checker.sv
// ----------------------------------------------------------------------------
// ssf_checker
// Port-level checks on the display formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssf_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_ready,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_segments,
    input  logic [3:0]  m_digit_enable
);
    import ssf_pkg::*;

    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_segments) && $stable(m_digit_enable), "stalled result changed")
    `ASSERT_IMP(a_enable_onehot, aclk, aresetn, m_valid, $onehot(m_digit_enable), "digit enable not one-hot")
    `ASSERT_IMP(a_minus_left, aclk, aresetn, m_valid && m_segments[6:0] == SEG_MINUS[6:0], m_digit_enable[3], "minus glyph off the leftmost digit")
    `ASSERT_IMP(a_point_place, aclk, aresetn, m_valid && m_segments[7], m_digit_enable[2] || m_digit_enable[3], "point on a digit that never carries one")
    `ASSERT_RST(a_reset_state, aclk, aresetn, !m_valid && s_ready, "not empty and ready after reset")

endmodule

bind seven_segment_four_digit_formatter ssf_checker u_ssf_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_segments     (m_segments),
    .m_digit_enable (m_digit_enable)
);

FILE: sim/segment_pattern_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_pattern_checker
// Watches both channels of the display formatter, keeps its own copy of the
// stored digits, minus glyph and point, and checks every scan pattern.
// ----------------------------------------------------------------------------
module segment_pattern_checker
    import ssf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic signed [17:0] s_value,
    input  logic [1:0]         s_digit_index,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [7:0]         m_segments,
    input  logic [3:0]         m_digit_enable,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [7:0] segments;
        logic [3:0] enable;
    } pattern_t;

    localparam logic [7:0] DIGIT_GLYPH [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    digit_t     shown [4];
    logic       minus_on;
    logic [1:0] point_at;
    pattern_t   pattern_queue [$];

    function automatic void put_digits(input int d3, input int d2, input int d1,
                                       input int d0);
        shown[3] = 4'(d3);
        shown[2] = 4'(d2);
        shown[1] = 4'(d1);
        shown[0] = 4'(d0);
    endfunction

    function automatic void load_integer_digits(input int v);
        int u;
        u = (v < 0) ? 0 : ((v > 9999) ? 9999 : v);
        put_digits(u / 1000, (u % 1000) / 100, (u % 100) / 10, u % 10);
        minus_on = 1'b0;
        point_at = POINT_NONE;
    endfunction

    // Value in thousandths; fraction below the shown resolution is truncated
    function automatic void load_fixed_digits(input int v);
        int mag;
        int whole;
        int frac;
        int hund;
        mag   = (v < 0) ? -v : v;
        whole = mag / 1000;
        frac  = mag % 1000;
        hund  = frac / 10;
        if (v >= 10000 && v <= 99999) begin
            put_digits(whole / 10, whole % 10, hund / 10, hund % 10);
            minus_on = 1'b0;
            point_at = POINT_TWO;
        end else if (v >= -999 && v <= 9999) begin
            // small negatives lose their sign here
            put_digits(whole, frac / 100, (frac % 100) / 10, frac % 10);
            minus_on = 1'b0;
            point_at = POINT_THREE;
        end else if (v >= -9999 && v <= -1000) begin
            put_digits(0, whole, hund / 10, hund % 10);
            minus_on = 1'b1;
            point_at = POINT_TWO;
        end else begin
            put_digits(0, 0, 0, 0);
            minus_on = 1'b0;
            point_at = POINT_NONE;
        end
    endfunction

    function automatic pattern_t scan_pattern(input logic [1:0] idx);
        pattern_t p;
        if (idx == MINUS_POS && minus_on) begin
            p.segments = SEG_MINUS;
        end else begin
            p.segments = (shown[idx] < 4'd10) ? DIGIT_GLYPH[shown[idx]] : SEG_BLANK;
        end
        if (point_at != POINT_NONE && idx == point_at) begin
            p.segments = p.segments | SEG_POINT;
        end
        p.enable = 4'b0001 << idx;
        return p;
    endfunction

    always @(posedge aclk) begin
        pattern_t want;
        if (!aresetn) begin
            put_digits(0, 0, 0, 0);
            minus_on   = 1'b0;
            point_at   = POINT_NONE;
            fail_count = 0;
            pattern_queue.delete();
        end else begin
            // result side first: a scan cannot come out in its own cycle
            if (m_valid && m_ready) begin
                if (pattern_queue.size() == 0) begin
                    $error("unexpected result transfer: segments %h, digit_enable %h",
                           m_segments, m_digit_enable);
                    fail_count++;
                end else begin
                    want = pattern_queue.pop_front();
                    if (m_segments !== want.segments) begin
                        $error("segments: expected %h, got %h", want.segments, m_segments);
                        fail_count++;
                    end
                    if (m_digit_enable !== want.enable) begin
                        $error("digit_enable: expected %h, got %h",
                               want.enable, m_digit_enable);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                case (s_command)
                    CMD_LOAD_INT: load_integer_digits(int'(s_value));
                    CMD_LOAD_FIX: load_fixed_digits(int'(s_value));
                    CMD_SCAN:     pattern_queue.push_back(scan_pattern(s_digit_index));
                    default:      ;
                endcase
            end
        end
        pending <= pattern_queue.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the display formatter with loads and scans under varying back
// pressure; the checker beside the block predicts and compares each pattern.
// ----------------------------------------------------------------------------
module tb;
    import ssf_pkg::*;

    // Unused command code; the block must ignore it
    localparam logic [1:0] CMD_IGNORED = 2'd3;

    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 16;     // generous margin over the latency
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEMS_PER_PHASE = 325;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_command     = CMD_LOAD_INT;
    logic signed [17:0] s_value       = '0;
    logic [1:0]         s_digit_index = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_segments;
    logic [3:0]         m_digit_enable;

    int fail_count;
    int pending;
    int cycle_count    = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    always #6 aclk = ~aclk;

    seven_segment_four_digit_formatter u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_value        (s_value),
        .s_digit_index  (s_digit_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_segments     (m_segments),
        .m_digit_enable (m_digit_enable)
    );

    segment_pattern_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_value        (s_value),
        .s_digit_index  (s_digit_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_segments     (m_segments),
        .m_digit_enable (m_digit_enable),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // Receiver: stalls at the rate set by the current phase
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // One transfer on s_: random idle cycles first, then valid held until taken
    task automatic send_item(input logic [1:0] cmd, input logic [17:0] val,
                             input logic [1:0] idx);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_value       <= val;
        s_digit_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Sender goes quiet until the checker holds no outstanding pattern.
    // pending is registered, so wait for a clock edge before trusting it.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Value spread over the load ranges, their edges, and the full 18 bits
    function automatic logic [17:0] pick_value();
        int region;
        int v;
        region = $urandom_range(0, 9);
        case (region)
            0, 1:    v = $urandom_range(10000, 99999);
            2, 3:    v = int'($urandom_range(0, 10998)) - 999;
            4, 5:    v = -int'($urandom_range(1000, 9999));
            6:       v = $urandom_range(0, 9999);
            7:       v = $urandom();
            default: begin
                case ($urandom_range(0, 11))
                    0:       v = -131072;
                    1:       v = 131071;
                    2:       v = 100000;
                    3:       v = -10000;
                    4:       v = -1000;
                    5:       v = -999;
                    6:       v = -1;
                    7:       v = 0;
                    8:       v = 9999;
                    9:       v = 10000;
                    10:      v = 99999;
                    default: v = -9999;
                endcase
            end
        endcase
        return 18'(v);
    endfunction

    // Mostly a load followed by a few scans; some ignored commands and
    // fully random items mixed in as noise
    task automatic run_phase(input int idle_pct, input int stall_pct, input int items);
        int sent;
        int scans;
        int roll;
        sent = 0;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        while (sent < items) begin
            roll = $urandom_range(0, 99);
            if (roll < 85) begin
                send_item($urandom_range(0, 1) ? CMD_LOAD_FIX : CMD_LOAD_INT,
                          pick_value(), 2'($urandom()));
                sent++;
                scans = $urandom_range(1, 4);
                repeat (scans) begin
                    send_item(CMD_SCAN, 18'($urandom()), 2'($urandom()));
                    sent++;
                end
            end else if (roll < 92) begin
                send_item(CMD_IGNORED, 18'($urandom()), 2'($urandom()));
            end else begin
                send_item(2'($urandom_range(0, 2)), 18'($urandom()), 2'($urandom()));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset display, saturation, each fixed range and its edges
        send_item(CMD_SCAN, 18'd0, 2'd0);
        send_item(CMD_SCAN, 18'd0, 2'd3);
        send_item(CMD_LOAD_INT, 18'd9999, 2'd0);
        send_item(CMD_SCAN, 18'd0, 2'd3);
        send_item(CMD_SCAN, 18'h3FFFF, 2'd0);
        send_item(CMD_LOAD_INT, 18'h20000, 2'd3);        // most negative: clamps to 0
        send_item(CMD_SCAN, 18'd0, 2'd1);
        send_item(CMD_LOAD_INT, 18'h1FFFF, 2'd1);        // clamps to 9999
        send_item(CMD_SCAN, 18'd0, 2'd2);
        send_item(CMD_LOAD_FIX, 18'd99999, 2'd2);        // thousandth truncated
        send_item(CMD_SCAN, 18'd0, 2'd2);
        send_item(CMD_SCAN, 18'd0, 2'd0);
        send_item(CMD_LOAD_FIX, -18'sd1, 2'd0);          // tiny negative shows as positive
        send_item(CMD_SCAN, 18'd0, 2'd3);
        send_item(CMD_SCAN, 18'd0, 2'd0);
        send_item(CMD_LOAD_FIX, -18'sd9999, 2'd0);       // minus glyph, point on two
        send_item(CMD_SCAN, 18'd0, 2'd3);
        send_item(CMD_SCAN, 18'd0, 2'd2);
        send_item(CMD_LOAD_FIX, -18'sd1000, 2'd0);
        send_item(CMD_SCAN, 18'd0, 2'd1);
        send_item(CMD_LOAD_FIX, 18'd10000, 2'd0);
        send_item(CMD_SCAN, 18'd0, 2'd3);
        send_item(CMD_LOAD_FIX, 18'd100000, 2'd0);       // out of range: zeros, no point
        send_item(CMD_SCAN, 18'd0, 2'd2);
        send_item(CMD_IGNORED, 18'h3FFFF, 2'd3);         // must leave state alone
        send_item(CMD_SCAN, 18'd0, 2'd2);

        // Random phases; the first boundary is the full-drain pause
        run_phase(0, 0, ITEMS_PER_PHASE);
        wait_for_drain();
        run_phase(56, 0, ITEMS_PER_PHASE);
        run_phase(0, 56, ITEMS_PER_PHASE);
        run_phase(24, 24, ITEMS_PER_PHASE);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
